### src/stack_cell_integer_alu_assert.svh
// Assertion macros for the stack cell integer ALU.
`ifndef STACK_CELL_INTEGER_ALU_ASSERT_SVH
`define STACK_CELL_INTEGER_ALU_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication
`define SCIA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scia: implication check failed");
// Next-cycle implication
`define SCIA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scia: sequence check failed");
`else
`define SCIA_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SCIA_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

### src/scia_pkg.sv
// Shared types, word codes and helpers for the stack cell integer ALU.
package scia_pkg;

  localparam int CELL_BITS   = 32;
  localparam int DBL_BITS    = 2 * CELL_BITS;
  localparam int CNT_BITS    = $clog2(DBL_BITS);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  // Word codes, in order
  typedef enum logic [4:0] {
    W_ADD, W_DADD, W_MADD, W_SUB, W_DSUB, W_MUL, W_UMMUL, W_MMUL,
    W_DIV, W_MOD, W_DIVMOD, W_UDIVMOD, W_SMREM, W_FMMOD, W_SCDIV, W_SCDIVMOD,
    W_INC1, W_DEC1, W_INC2, W_DEC2, W_SHL, W_SHR, W_ABS, W_DABS,
    W_NEG, W_DNEG, W_MIN, W_DMIN, W_MAX, W_DMAX
  } word_t;

  // Which back-end path an item takes
  typedef enum logic [1:0] {K_ALU, K_MUL, K_DIV, K_SCALE} kind_t;

  typedef struct packed {
    logic        [4:0]  action;
    logic signed [63:0] first_operand;
    logic signed [63:0] second_operand;
    logic signed [31:0] third_operand;
  } req_t;

  typedef struct packed {
    logic signed [63:0] primary_value;
    logic signed [31:0] remainder_value;
    logic               has_remainder;
    logic               is_double;
    logic               divide_error;
  } res_t;

  // Decoded item passed from front to back
  typedef struct packed {
    kind_t       kind;
    logic [4:0]  action;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic        hasr;
    logic        dbl;
  } cmd_t;

  // Sign-extend the low cell of a word
  function automatic logic [63:0] sx_cell(input logic [63:0] v);
    logic signed [63:0] t;
    t = v << (64 - CELL_BITS);
    return t >>> (64 - CELL_BITS);
  endfunction

  // Sign-extend the low double cell of a word
  function automatic logic [63:0] sx_dbl(input logic [63:0] v);
    logic signed [63:0] t;
    t = v << (64 - DBL_BITS);
    return t >>> (64 - DBL_BITS);
  endfunction

  // Zero-extend the low cell of a word
  function automatic logic [63:0] zx_cell(input logic [63:0] v);
    logic [63:0] t;
    t = v << (64 - CELL_BITS);
    return t >> (64 - CELL_BITS);
  endfunction

endpackage

### src/scia_front.sv
// Front end: accepts items, decodes the word and prepares operands.
module scia_front import scia_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t request,
  output logic busy,
  input  logic full,
  output logic push,
  output cmd_t cmd
);

  logic valid;
  logic load;
  cmd_t cmd_next;

  // Handshake: hold the decoded item until the queue has room
  assign push = valid && !full;
  assign busy = valid && full;
  assign load = start && !busy;

  // Decode
  always_comb begin
    cmd_next.kind   = K_ALU;
    cmd_next.action = request.action;
    cmd_next.a      = sx_cell(request.first_operand);
    cmd_next.b      = sx_cell(request.second_operand);
    cmd_next.c      = sx_cell({{32{request.third_operand[31]}}, request.third_operand});
    cmd_next.hasr   = 1'b0;
    cmd_next.dbl    = 1'b0;
    unique case (request.action)
      W_DADD, W_DSUB, W_DMIN, W_DMAX, W_DABS, W_DNEG: begin
        cmd_next.a   = sx_dbl(request.first_operand);
        cmd_next.b   = sx_dbl(request.second_operand);
        cmd_next.dbl = 1'b1;
      end
      W_MADD: begin
        cmd_next.a   = sx_dbl(request.first_operand);
        cmd_next.dbl = 1'b1;
      end
      W_MUL: cmd_next.kind = K_MUL;
      W_UMMUL: begin
        cmd_next.kind = K_MUL;
        cmd_next.a    = zx_cell(request.first_operand);
        cmd_next.b    = zx_cell(request.second_operand);
        cmd_next.dbl  = 1'b1;
      end
      W_MMUL: begin
        cmd_next.kind = K_MUL;
        cmd_next.dbl  = 1'b1;
      end
      W_DIV, W_MOD: cmd_next.kind = K_DIV;
      W_DIVMOD: begin
        cmd_next.kind = K_DIV;
        cmd_next.hasr = 1'b1;
      end
      W_UDIVMOD: begin
        cmd_next.kind = K_DIV;
        cmd_next.hasr = 1'b1;
        cmd_next.a    = zx_cell(request.first_operand);
        cmd_next.b    = zx_cell(request.second_operand);
      end
      W_SMREM, W_FMMOD: begin
        cmd_next.kind = K_DIV;
        cmd_next.hasr = 1'b1;
        cmd_next.a    = sx_dbl(request.first_operand);
      end
      W_SCDIV: cmd_next.kind = K_SCALE;
      W_SCDIVMOD: begin
        cmd_next.kind = K_SCALE;
        cmd_next.hasr = 1'b1;
      end
      default: ;
    endcase
  end

  // Item register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (push) begin
      valid <= 1'b0;
    end
    if (load) begin
      cmd <= cmd_next;
    end
  end

endmodule

### src/scia_queue.sv
// Short item queue between the front and back ends.
module scia_queue import scia_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  cmd_t                 mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;

  assign full  = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

### src/scia_back.sv
// Back end: simple ALU, cell multiplier and bit-serial divider.
module scia_back import scia_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  input  logic empty,
  output logic pop,
  output logic done,
  output res_t result
);

  `include "stack_cell_integer_alu_assert.svh"

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIN} state_t;

  state_t                state;
  cmd_t                  cur;
  logic [63:0]           prod;
  logic [63:0]           dvd;
  logic [CELL_BITS-1:0]  rem;
  logic [CELL_BITS-1:0]  dvs;
  logic                  neg_a;
  logic                  neg_b;
  logic [CNT_BITS-1:0]   cnt;

  logic [63:0]                   alu_p;
  logic signed [CELL_BITS:0]     ma;
  logic signed [CELL_BITS:0]     mb;
  logic signed [2*CELL_BITS+1:0] mul_full;
  logic [63:0]                   sel_dvd;
  logic [63:0]                   sel_dvs;
  logic                          dvs_zero;
  logic [63:0]                   dvd_mag;
  logic [63:0]                   dvs_mag;
  logic [CELL_BITS:0]            trial;
  logic                          ge;
  logic [63:0]                   fin_q;
  logic [63:0]                   fin_r;
  res_t                          fin_res;

  assign pop = (state == S_IDLE) && !empty;

  // Combinational ALU words
  always_comb begin
    unique case (cmd.action)
      W_ADD, W_DADD, W_MADD: alu_p = cmd.a + cmd.b;
      W_SUB, W_DSUB:         alu_p = cmd.a - cmd.b;
      W_INC1:                alu_p = cmd.a + 64'd1;
      W_DEC1:                alu_p = cmd.a - 64'd1;
      W_INC2:                alu_p = cmd.a + 64'd2;
      W_DEC2:                alu_p = cmd.a - 64'd2;
      W_SHL:                 alu_p = cmd.a << 1;
      W_SHR:                 alu_p = $signed(cmd.a) >>> 1;
      W_ABS, W_DABS:         alu_p = cmd.a[63] ? (64'd0 - cmd.a) : cmd.a;
      W_NEG, W_DNEG:         alu_p = 64'd0 - cmd.a;
      W_MIN, W_DMIN:         alu_p = ($signed(cmd.b) < $signed(cmd.a)) ? cmd.b : cmd.a;
      W_MAX, W_DMAX:         alu_p = ($signed(cmd.b) < $signed(cmd.a)) ? cmd.a : cmd.b;
      default:               alu_p = 64'd0;
    endcase
    alu_p = cmd.dbl ? sx_dbl(alu_p) : sx_cell(alu_p);
  end

  // Cell multiplier; the extra bit carries sign or zero extension
  assign ma       = cmd.a[CELL_BITS:0];
  assign mb       = cmd.b[CELL_BITS:0];
  assign mul_full = ma * mb;

  // Divider operand selection: direct words from the queue, scaled words from the product
  always_comb begin
    if (state == S_MUL) begin
      sel_dvd = prod;
      sel_dvs = cur.c;
    end else begin
      sel_dvd = cmd.a;
      sel_dvs = cmd.b;
    end
    dvs_zero = (sel_dvs == 64'd0);
    dvd_mag  = sel_dvd[63] ? (64'd0 - sel_dvd) : sel_dvd;
    dvs_mag  = sel_dvs[63] ? (64'd0 - sel_dvs) : sel_dvs;
  end

  // One quotient bit per cycle
  assign trial = {rem, dvd[DBL_BITS-1]};
  assign ge    = (trial >= {1'b0, dvs});

  // Sign correction and floor adjustment
  always_comb begin
    fin_q = (neg_a != neg_b) ? (64'd0 - dvd) : dvd;
    fin_r = neg_a ? (64'd0 - {{(64-CELL_BITS){1'b0}}, rem})
                  : {{(64-CELL_BITS){1'b0}}, rem};
    if ((cur.action == W_FMMOD) && (rem != '0) && (neg_a != neg_b)) begin
      fin_q = fin_q - 64'd1;
      fin_r = fin_r + cur.b;
    end
    fin_res.has_remainder = cur.hasr;
    fin_res.is_double     = 1'b0;
    fin_res.divide_error  = 1'b0;
    if (cur.action == W_MOD) begin
      fin_res.primary_value   = sx_cell(fin_r);
      fin_res.remainder_value = 32'd0;
    end else begin
      fin_res.primary_value   = sx_cell(fin_q);
      fin_res.remainder_value = cur.hasr ? fin_r[31:0] : 32'd0;
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            cur <= cmd;
            unique case (cmd.kind)
              K_ALU: begin
                result <= '{alu_p, 32'd0, 1'b0, cmd.dbl, 1'b0};
                done   <= 1'b1;
              end
              K_MUL, K_SCALE: begin
                prod  <= 64'(mul_full);
                state <= S_MUL;
              end
              K_DIV: begin
                if (dvs_zero) begin
                  result <= '{64'd0, 32'd0, cmd.hasr, cmd.dbl, 1'b1};
                  done   <= 1'b1;
                end else begin
                  neg_a <= sel_dvd[63];
                  neg_b <= sel_dvs[63];
                  dvd   <= dvd_mag;
                  dvs   <= dvs_mag[CELL_BITS-1:0];
                  rem   <= '0;
                  cnt   <= CNT_BITS'(DBL_BITS - 1);
                  state <= S_DIV;
                end
              end
              default: ;
            endcase
          end
        end
        S_MUL: begin
          if (cur.kind == K_MUL) begin
            result <= '{(cur.dbl ? sx_dbl(prod) : sx_cell(prod)), 32'd0, 1'b0, cur.dbl, 1'b0};
            done   <= 1'b1;
            state  <= S_IDLE;
          end else if (dvs_zero) begin
            result <= '{64'd0, 32'd0, cur.hasr, 1'b0, 1'b1};
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            neg_a <= sel_dvd[63];
            neg_b <= sel_dvs[63];
            dvd   <= dvd_mag;
            dvs   <= dvs_mag[CELL_BITS-1:0];
            rem   <= '0;
            cnt   <= CNT_BITS'(DBL_BITS - 1);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // partial remainder stays below the divisor, so the low cell holds it
          rem <= ge ? (trial[CELL_BITS-1:0] - dvs) : trial[CELL_BITS-1:0];
          dvd <= {dvd[62:0], ge};
          if (cnt == '0) begin
            state <= S_FIN;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_FIN: begin
          result <= fin_res;
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  `SCIA_ASSERT_IMP(a_err_zero, clk, rst, done && result.divide_error,
                   result.primary_value == 64'd0 && result.remainder_value == 32'd0)
  `SCIA_ASSERT_NXT(a_div_end, clk, rst, state == S_DIV && cnt == '0, state == S_FIN)
  `SCIA_ASSERT_NXT(a_fin_done, clk, rst, state == S_FIN, done && state == S_IDLE)
  `SCIA_ASSERT_IMP(a_no_rem, clk, rst, done && !result.has_remainder,
                   result.remainder_value == 32'd0)

endmodule

### src/stack_cell_integer_alu.sv
// Top level of the stack cell integer ALU.
// Usage:
//   Drive request (word code and up to three operands) and raise start; the
//   item is taken at a rising edge where start is high and busy is low.
//   Each item gives one result on result, marked by done for one cycle.
//   The receiver cannot hold results off; results leave in item order.
// Paths and throughput:
//   Add, subtract, shift, abs, negate, min and max words: front register,
//   queue, then result register; one item per cycle sustained while no
//   multiply or divide word holds the back end.
//   Multiply words: cell multiplier, then result register; the back end
//   takes no new item until the result is out. Divide words: the
//   one-bit-per-cycle divider, then sign correction; scaled words first
//   pass the multiplier. A zero divisor skips the divider, with divide_error.
//   A two-entry queue lets the front keep accepting while the back works;
//   busy rises when the queue and the front register are both full.
// Reset: rst (synchronous) clears the front register, empties the queue and
// returns the back end to idle; items in flight give no result after reset.
module stack_cell_integer_alu import scia_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t request,
  output logic busy,
  output logic done,
  output res_t result
);

  logic full;
  logic push;
  cmd_t front_cmd;
  logic pop;
  logic empty;
  cmd_t head_cmd;

  scia_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .full    (full),
    .push    (push),
    .cmd     (front_cmd)
  );

  scia_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (front_cmd),
    .full  (full),
    .pop   (pop),
    .dout  (head_cmd),
    .empty (empty)
  );

  scia_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cmd    (head_cmd),
    .empty  (empty),
    .pop    (pop),
    .done   (done),
    .result (result)
  );

endmodule

### tb/tb_stack_cell_integer_alu.sv
// Self-checking testbench for the stack cell integer ALU: predicts each word's result and compares.
module tb_stack_cell_integer_alu;
  timeunit 1ns;
  timeprecision 1ps;
  import scia_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM       = 630;

  // Tracks expected results in item order
  class alu_scoreboard;
    res_t pending[$];
    int   errors;

    // Sign-extend a cell to 64 bits
    static function logic [63:0] cell_sx(logic [63:0] v);
      return {{32{v[31]}}, v[31:0]};
    endfunction

    // Truncating signed divide of 64-bit values
    static function void trunc_div(logic signed [63:0] a, logic signed [63:0] b,
                                   output logic [63:0] q, output logic [63:0] r);
      logic [63:0] ma, mb, qa, ra;
      ma = a[63] ? -a : a;
      mb = b[63] ? -b : b;
      qa = ma / mb;
      ra = ma % mb;
      q = (a[63] != b[63]) ? -qa : qa;
      r = a[63] ? -ra : ra;
    endfunction

    // Work out the result of one word
    static function res_t evaluate(req_t rq);
      res_t e;
      logic [63:0] n1, n2, n3, d1, d2, u1, u2, p, r, q;
      logic hasr, dbl, derr;
      n1 = cell_sx(rq.first_operand);
      n2 = cell_sx(rq.second_operand);
      n3 = cell_sx({32'd0, rq.third_operand});
      d1 = rq.first_operand;
      d2 = rq.second_operand;
      u1 = {32'd0, rq.first_operand[31:0]};
      u2 = {32'd0, rq.second_operand[31:0]};
      p = '0; r = '0; q = '0; hasr = 0; dbl = 0; derr = 0;
      case (rq.action)
        W_ADD:   p = n1 + n2;
        W_DADD:  begin p = d1 + d2; dbl = 1; end
        W_MADD:  begin p = d1 + n2; dbl = 1; end
        W_SUB:   p = n1 - n2;
        W_DSUB:  begin p = d1 - d2; dbl = 1; end
        W_MUL:   p = n1 * n2;
        W_UMMUL: begin p = u1 * u2; dbl = 1; end
        W_MMUL:  begin p = n1 * n2; dbl = 1; end
        W_DIV, W_MOD, W_DIVMOD: begin
          hasr = (rq.action == W_DIVMOD);
          if (n2 == 0) derr = 1;
          else begin
            trunc_div(n1, n2, q, r);
            p = (rq.action == W_MOD) ? r : q;
          end
          if (rq.action != W_DIVMOD) r = '0;
        end
        W_UDIVMOD: begin
          hasr = 1;
          if (u2 == 0) derr = 1;
          else begin p = u1 / u2; r = u1 % u2; end
        end
        W_SMREM, W_FMMOD: begin
          hasr = 1;
          if (n2 == 0) derr = 1;
          else begin
            trunc_div(d1, n2, q, r);
            // floored form moves a remainder of the wrong sign
            if (rq.action == W_FMMOD && r != 0 && r[63] != n2[63]) begin
              q = q - 1;
              r = r + n2;
            end
            p = q;
          end
        end
        W_SCDIV, W_SCDIVMOD: begin
          hasr = (rq.action == W_SCDIVMOD);
          if (n3 == 0) derr = 1;
          else begin
            trunc_div(n1 * n2, n3, q, r);
            p = q;
            if (rq.action == W_SCDIV) r = '0;
          end
        end
        W_INC1: p = n1 + 1;
        W_DEC1: p = n1 - 1;
        W_INC2: p = n1 + 2;
        W_DEC2: p = n1 - 2;
        W_SHL:  p = n1 << 1;
        W_SHR:  p = $signed(n1) >>> 1;
        W_ABS:  p = n1[63] ? -n1 : n1;
        W_DABS: begin p = d1[63] ? -d1 : d1; dbl = 1; end
        W_NEG:  p = -n1;
        W_DNEG: begin p = -d1; dbl = 1; end
        W_MIN:  p = ($signed(n2) < $signed(n1)) ? n2 : n1;
        W_DMIN: begin p = ($signed(d2) < $signed(d1)) ? d2 : d1; dbl = 1; end
        W_MAX:  p = ($signed(n2) < $signed(n1)) ? n1 : n2;
        W_DMAX: begin p = ($signed(d2) < $signed(d1)) ? d1 : d2; dbl = 1; end
        default: ;
      endcase
      if (derr) begin p = '0; r = '0; end
      e.primary_value   = dbl ? p : cell_sx(p);
      e.remainder_value = r[31:0];
      e.has_remainder   = hasr;
      e.is_double       = dbl;
      e.divide_error    = derr;
      return e;
    endfunction

    function void note_item(req_t rq);
      pending.push_back(evaluate(rq));
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (pending.size() == 0) begin
        $error("result with none expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.primary_value !== e.primary_value) begin
        $error("primary_value exp %h got %h", e.primary_value, got.primary_value); errors++;
      end
      if (got.remainder_value !== e.remainder_value) begin
        $error("remainder_value exp %h got %h", e.remainder_value, got.remainder_value);
        errors++;
      end
      if (got.has_remainder !== e.has_remainder) begin
        $error("has_remainder exp %b got %b", e.has_remainder, got.has_remainder); errors++;
      end
      if (got.is_double !== e.is_double) begin
        $error("is_double exp %b got %b", e.is_double, got.is_double); errors++;
      end
      if (got.divide_error !== e.divide_error) begin
        $error("divide_error exp %b got %b", e.divide_error, got.divide_error); errors++;
      end
    endfunction
  endclass

  logic clk, rst, start, busy, done;
  req_t request;
  res_t result;
  alu_scoreboard sb;
  int idle_cycles;
  bit stim_done;

  stack_cell_integer_alu u_dut (
    .clk(clk), .rst(rst), .start(start), .request(request),
    .busy(busy), .done(done), .result(result)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Sample results and note accepted items; watchdog on no progress
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(result);
      if (start && !busy) sb.note_item(request);
      if (done || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[stack_cell_integer_alu] ERROR");
        $finish;
      end
    end
  end

  // Random operand with bias towards edge values
  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return 64'hffff_ffff_8000_0000 ^ {32'd0, 32'($urandom_range(0, 3))};
      3: return {32'($urandom), 32'($urandom_range(0, 3)) - 32'd1};
      4: return 64'($signed(32'($urandom)));
      5: return 64'($urandom_range(0, 20)) - 64'd10;
      default: return {32'($urandom), 32'($urandom)};
    endcase
  endfunction

  // Random gap before an item: mostly short, some long
  task automatic sender_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n) @(negedge clk) start <= 0;
  endtask

  // Present one item and hold until taken
  task automatic send_item(logic [4:0] act, logic [63:0] a, logic [63:0] b,
                           logic [31:0] c);
    sender_gap();
    @(negedge clk);
    start <= 1;
    request <= '{action: act, first_operand: a, second_operand: b, third_operand: c};
    do @(posedge clk); while (busy);
  endtask

  initial begin
    int k;
    sb = new();
    rst = 1; start = 0; request = '0; idle_cycles = 0; stim_done = 0;
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 0;
    // directed: even-numbered word codes on edge operands, zero divisors, unused codes
    for (k = 0; k < 30; k += 2)
      send_item(5'(k), 64'h8000_0000_8000_0000, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff);
    send_item(W_DIV, 64'h8000_0000, 64'hffff_ffff, 32'd0);
    send_item(W_DIVMOD, 64'd7, 64'd0, 32'd0);
    send_item(W_UDIVMOD, 64'd7, 64'd0, 32'd1);
    send_item(W_FMMOD, -64'sd7, 64'd2, 32'd0);
    send_item(W_SMREM, 64'd7, 64'd0, 32'd0);
    send_item(W_SCDIVMOD, 64'h7fff_ffff, 64'h7fff_ffff, 32'd0);
    send_item(W_DABS, 64'h8000_0000_0000_0000, 64'd0, 32'd0);
    send_item(W_SHR, -64'sd3, 64'd0, 32'd0);
    send_item(5'd30, 64'd5, 64'd5, 32'd5);
    send_item(5'd31, 64'd5, 64'd5, 32'd5);
    // random words
    for (k = 0; k < N_RANDOM; k++)
      send_item(5'($urandom_range(0, 31)), pick_operand(), pick_operand(),
                ($urandom_range(0, 7) == 0) ? 32'd0 : 32'(pick_operand()));
    @(negedge clk) start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) $display("[stack_cell_integer_alu] OK");
    else $display("[stack_cell_integer_alu] ERROR");
    $finish;
  end
endmodule

### stack_cell_integer_alu.f
+incdir+src
src/scia_pkg.sv
src/scia_front.sv
src/scia_queue.sv
src/scia_back.sv
src/stack_cell_integer_alu.sv
tb/tb_stack_cell_integer_alu.sv
